@@ rtl/round_robin_process_scheduler_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Round-robin scheduler assertion macros
// Shared property forms for the port checker; clk and rst_n come from the
// module that uses them.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_PROCESS_SCHEDULER_UNIT_DEFINES_SVH
`define ROUND_ROBIN_PROCESS_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication
`define RRPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RRPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rrps_pkg.sv @@
// ----------------------------------------------------------------------------
// Round-robin scheduler package
// Operation, run-state and status codes, sequencer states, fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package rrps_pkg;

  localparam int KIND_W   = 2;
  localparam int PID_W    = 8;
  localparam int PST_W    = 3;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_SET    = 2'd2,
    KIND_SCHED  = 2'd3
  } kind_t;

  localparam logic [PST_W-1:0] PST_RUNNING = 3'd0;
  localparam logic [PST_W-1:0] PST_READY   = 3'd1;
  localparam logic [PST_W-1:0] PST_DEAD    = 3'd3;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_NOT_FOUND = 3'd1,
    STAT_PROTECTED = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_NO_READY  = 3'd4
  } status_t;

  // pids that may never be removed, and the smallest ring that allows removal
  localparam int PID_PROT_IDLE    = 0;
  localparam int PID_PROT_INIT    = 1;
  localparam int MIN_REMOVE_COUNT = 3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_ADD_RD,
    S_ADD_EV,
    S_RM_RD,
    S_RM_EV,
    S_SET_RD,
    S_SET_EV,
    S_SCH_RD0,
    S_SCH_EV0,
    S_SCH_RD,
    S_SCH_EV,
    S_FIN_RD,
    S_DONE
  } fsm_t;

endpackage

`default_nettype wire

@@ rtl/rrps_if.sv @@
// ----------------------------------------------------------------------------
// Round-robin scheduler channels
// Request channel (operation in) and result channel (ring status out).
// ----------------------------------------------------------------------------
`default_nettype none

interface rrps_in_if;
  import rrps_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [PID_W-1:0]   pid;
  logic [PST_W-1:0]   new_state;

  modport source (output valid, output kind, output pid, output new_state, input ready);
  modport sink   (input valid, input kind, input pid, input new_state, output ready);
endinterface

interface rrps_out_if;
  import rrps_pkg::*;

  logic                valid;
  logic                ready;
  logic [PID_W-1:0]    current_pid;
  logic                current_valid;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  process_count;

  modport source (output valid, output current_pid, output current_valid,
                  output status, output process_count, input ready);
  modport sink   (input valid, input current_pid, input current_valid,
                  input status, input process_count, output ready);
endinterface

`default_nettype wire

@@ rtl/rrps_ram.sv @@
// ----------------------------------------------------------------------------
// Round-robin scheduler entry RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rrps_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/round_robin_process_scheduler_unit.sv @@
// Sequencing: a refused or trivial request goes straight to its result.
// Add scans for a free slot (up to MAX_ENTRIES), then walks the ring to link it in.
// Remove and set state walk the ring entries until the pid is found or the walk wraps.
// Schedule visits entries (up to 2*MAX_ENTRIES) until one is ready; a dead entry found
// on the way is removed by a ring walk when allowed. One request at a time.
// Reset clears ring membership, pointer and count at once; no clearing pass.
// ----------------------------------------------------------------------------
// Round-robin process scheduler
// Ring of process entries linked through an entry RAM, walked by a small
// sequencer for add, remove, set state and schedule requests.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_process_scheduler_unit #(
  parameter int MAX_ENTRIES = 16,
  parameter int PID_BITS    = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  rrps_in_if.sink     in_req,
  rrps_out_if.source  out_rsp
);
  import rrps_pkg::*;

  localparam int SLOT_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int STEP_W = $clog2(2 * MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(MAX_ENTRIES);
  localparam logic [CNT_W-1:0]  MIN_COUNT  = CNT_W'(MIN_REMOVE_COUNT);
  localparam logic [STEP_W-1:0] STEP_LIMIT = STEP_W'(2 * MAX_ENTRIES);
  localparam logic [PID_BITS-1:0] PROT_A = PID_BITS'(PID_PROT_IDLE);
  localparam logic [PID_BITS-1:0] PROT_B = PID_BITS'(PID_PROT_INIT);

  fsm_t                   state_r, state_nxt;
  logic [SLOT_W-1:0]      cur_r, cur_nxt;
  logic [CNT_W-1:0]       total_r, total_nxt;
  logic [SLOT_W-1:0]      walk_r, walk_nxt;
  logic [SLOT_W-1:0]      prev_r, prev_nxt;
  logic [SLOT_W-1:0]      scan_r, scan_nxt;
  logic [STEP_W-1:0]      steps_r, steps_nxt;
  logic                   sched_r, sched_nxt;
  logic [PID_BITS-1:0]    pid_r, pid_nxt;
  logic [PST_W-1:0]       nst_r, nst_nxt;
  status_t                status_r, status_nxt;
  logic [MAX_ENTRIES-1:0] used_r, used_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [PID_W-1:0]       out_pid_r, out_pid_nxt;
  logic                   out_cvalid_r, out_cvalid_nxt;
  logic [STATUS_W-1:0]    out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]     out_count_r, out_count_nxt;

  logic                   rd_en;
  logic [SLOT_W-1:0]      rd_addr;
  logic [SLOT_W-1:0]      wr_addr;
  logic                   we_pid, we_st, we_nxt;
  logic [PID_BITS-1:0]    wr_pid, rd_pid;
  logic [PST_W-1:0]       wr_st, rd_st;
  logic [SLOT_W-1:0]      wr_nxt, rd_nxt;

  logic                   in_acc;
  logic [PID_BITS-1:0]    pid_in;
  logic                   ring_empty, ring_full;
  logic                   refuse_in, refuse_rd;
  logic                   pid_match, wrap;
  logic                   out_free;

  rrps_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(PID_BITS)) u_pid_ram (
    .clk(clk), .we(we_pid), .waddr(wr_addr), .wdata(wr_pid),
    .re(rd_en), .raddr(rd_addr), .rdata(rd_pid)
  );

  rrps_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(PST_W)) u_st_ram (
    .clk(clk), .we(we_st), .waddr(wr_addr), .wdata(wr_st),
    .re(rd_en), .raddr(rd_addr), .rdata(rd_st)
  );

  rrps_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(SLOT_W)) u_nxt_ram (
    .clk(clk), .we(we_nxt), .waddr(wr_addr), .wdata(wr_nxt),
    .re(rd_en), .raddr(rd_addr), .rdata(rd_nxt)
  );

  assign in_req.ready = (state_r == S_IDLE);
  assign in_acc       = in_req.valid & in_req.ready;
  assign pid_in       = PID_BITS'(in_req.pid);
  assign ring_empty   = (total_r == '0);
  assign ring_full    = (total_r >= FULL_COUNT);
  assign refuse_in    = (pid_in == PROT_A) || (pid_in == PROT_B) || (total_r < MIN_COUNT);
  assign refuse_rd    = (rd_pid == PROT_A) || (rd_pid == PROT_B) || (total_r < MIN_COUNT);
  assign pid_match    = (rd_pid == pid_r);
  assign wrap         = (rd_nxt == cur_r);
  assign out_free     = !out_valid_r || out_rsp.ready;

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (kind_t'(in_req.kind))
            KIND_ADD:    state_nxt = ring_full  ? S_FIN_RD : S_ADD_SCAN;
            KIND_REMOVE: state_nxt = refuse_in  ? S_FIN_RD : S_RM_RD;
            KIND_SET:    state_nxt = ring_empty ? S_FIN_RD : S_SET_RD;
            KIND_SCHED:  state_nxt = ring_empty ? S_FIN_RD : S_SCH_RD0;
            default:     state_nxt = S_FIN_RD;
          endcase
        end
      end
      S_ADD_SCAN: begin
        if (!used_r[scan_r]) begin
          state_nxt = ring_empty ? S_FIN_RD : S_ADD_RD;
        end
      end
      S_ADD_RD:  state_nxt = S_ADD_EV;
      S_ADD_EV:  state_nxt = wrap ? S_FIN_RD : S_ADD_RD;
      S_RM_RD:   state_nxt = S_RM_EV;
      S_RM_EV: begin
        if (pid_match || wrap) begin
          state_nxt = sched_r ? S_SCH_RD : S_FIN_RD;
        end else begin
          state_nxt = S_RM_RD;
        end
      end
      S_SET_RD:  state_nxt = S_SET_EV;
      S_SET_EV:  state_nxt = (pid_match || wrap) ? S_FIN_RD : S_SET_RD;
      S_SCH_RD0: state_nxt = S_SCH_EV0;
      S_SCH_EV0: state_nxt = S_SCH_RD;
      S_SCH_RD:  state_nxt = (steps_r == STEP_LIMIT) ? S_FIN_RD : S_SCH_EV;
      S_SCH_EV: begin
        if (rd_st == PST_READY) begin
          state_nxt = S_FIN_RD;
        end else if (rd_st == PST_DEAD && !refuse_rd) begin
          state_nxt = S_RM_RD;
        end else begin
          state_nxt = S_SCH_RD;
        end
      end
      S_FIN_RD:  state_nxt = S_DONE;
      S_DONE:    state_nxt = out_free ? S_IDLE : S_DONE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath, entry RAM control and result register
  always_comb begin
    cur_nxt        = cur_r;
    total_nxt      = total_r;
    walk_nxt       = walk_r;
    prev_nxt       = prev_r;
    scan_nxt       = scan_r;
    steps_nxt      = steps_r;
    sched_nxt      = sched_r;
    pid_nxt        = pid_r;
    nst_nxt        = nst_r;
    status_nxt     = status_r;
    used_nxt       = used_r;
    rd_en          = 1'b0;
    rd_addr        = walk_r;
    wr_addr        = walk_r;
    we_pid         = 1'b0;
    we_st          = 1'b0;
    we_nxt         = 1'b0;
    wr_pid         = pid_r;
    wr_st          = nst_r;
    wr_nxt         = cur_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_pid_nxt    = out_pid_r;
    out_cvalid_nxt = out_cvalid_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          pid_nxt    = pid_in;
          nst_nxt    = in_req.new_state;
          walk_nxt   = cur_r;
          scan_nxt   = '0;
          sched_nxt  = 1'b0;
          status_nxt = STAT_OK;
          case (kind_t'(in_req.kind))
            KIND_ADD:    if (ring_full)  status_nxt = STAT_FULL;
            KIND_REMOVE: if (refuse_in)  status_nxt = STAT_PROTECTED;
            KIND_SET:    if (ring_empty) status_nxt = STAT_NOT_FOUND;
            KIND_SCHED:  if (ring_empty) status_nxt = STAT_NO_READY;
            default:     status_nxt = STAT_OK;
          endcase
        end
      end
      S_ADD_SCAN: begin
        if (used_r[scan_r]) begin
          scan_nxt = scan_r + 1'b1;
        end else begin
          wr_addr          = scan_r;
          we_pid           = 1'b1;
          we_st            = 1'b1;
          we_nxt           = 1'b1;
          wr_nxt           = ring_empty ? scan_r : cur_r;
          used_nxt[scan_r] = 1'b1;
          if (ring_empty) begin
            cur_nxt   = scan_r;
            total_nxt = total_r + 1'b1;
          end
        end
      end
      S_ADD_RD, S_RM_RD, S_SET_RD: begin
        rd_en = 1'b1;
      end
      S_ADD_EV: begin
        if (wrap) begin
          we_nxt    = 1'b1;
          wr_nxt    = scan_r;
          total_nxt = total_r + 1'b1;
        end else begin
          walk_nxt = rd_nxt;
        end
      end
      S_RM_EV: begin
        if (pid_match) begin
          status_nxt = STAT_OK;
          if (walk_r == cur_r) begin
            we_st = 1'b1;
            wr_st = PST_DEAD;
          end else begin
            wr_addr          = prev_r;
            we_nxt           = 1'b1;
            wr_nxt           = rd_nxt;
            used_nxt[walk_r] = 1'b0;
            total_nxt        = total_r - 1'b1;
          end
        end else if (wrap) begin
          status_nxt = STAT_NOT_FOUND;
        end else begin
          prev_nxt = walk_r;
          walk_nxt = rd_nxt;
        end
      end
      S_SET_EV: begin
        if (pid_match) begin
          we_st      = 1'b1;
          status_nxt = STAT_OK;
        end else if (wrap) begin
          status_nxt = STAT_NOT_FOUND;
        end else begin
          walk_nxt = rd_nxt;
        end
      end
      S_SCH_RD0, S_FIN_RD: begin
        rd_en   = 1'b1;
        rd_addr = cur_r;
      end
      S_SCH_EV0: begin
        wr_addr   = cur_r;
        we_st     = (rd_st == PST_RUNNING);
        wr_st     = PST_READY;
        cur_nxt   = rd_nxt;
        steps_nxt = '0;
      end
      S_SCH_RD: begin
        if (steps_r == STEP_LIMIT) begin
          status_nxt = STAT_NO_READY;
        end else begin
          rd_en   = 1'b1;
          rd_addr = cur_r;
        end
      end
      S_SCH_EV: begin
        if (rd_st == PST_READY) begin
          wr_addr    = cur_r;
          we_st      = 1'b1;
          wr_st      = PST_RUNNING;
          status_nxt = STAT_OK;
        end else begin
          cur_nxt   = rd_nxt;
          steps_nxt = steps_r + 1'b1;
          if (rd_st == PST_DEAD) begin
            pid_nxt   = rd_pid;
            walk_nxt  = rd_nxt;
            sched_nxt = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_pid_nxt    = ring_empty ? '0 : PID_W'(rd_pid);
          out_cvalid_nxt = !ring_empty;
          out_status_nxt = status_r;
          out_count_nxt  = COUNT_W'(total_r);
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      total_r     <= '0;
      used_r      <= '0;
      sched_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      total_r     <= total_nxt;
      used_r      <= used_nxt;
      sched_r     <= sched_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    walk_r       <= walk_nxt;
    prev_r       <= prev_nxt;
    scan_r       <= scan_nxt;
    steps_r      <= steps_nxt;
    pid_r        <= pid_nxt;
    nst_r        <= nst_nxt;
    status_r     <= status_nxt;
    out_pid_r    <= out_pid_nxt;
    out_cvalid_r <= out_cvalid_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.current_pid   = out_pid_r;
  assign out_rsp.current_valid = out_cvalid_r;
  assign out_rsp.status        = out_status_r;
  assign out_rsp.process_count = out_count_r;

endmodule

`default_nettype wire

@@ rtl/rrps_chk.sv @@
// ----------------------------------------------------------------------------
// Round-robin scheduler port checker
// Watches the request and result channels of the scheduler top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "round_robin_process_scheduler_unit_defines.svh"

module rrps_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [rrps_pkg::PID_W-1:0]    out_current_pid,
  input wire logic                          out_current_valid,
  input wire logic [rrps_pkg::STATUS_W-1:0] out_status,
  input wire logic [rrps_pkg::COUNT_W-1:0]  out_process_count
);
  import rrps_pkg::*;

  `RRPS_ASSERT_NEXT(a_busy_after_request, in_valid && in_ready, !in_ready, "ready stayed high after a request")
  `RRPS_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid), "result appeared one cycle after a request")
  `RRPS_ASSERT_NEXT(a_hold_result, out_valid && !out_ready, out_valid && $stable(out_current_pid) && $stable(out_status) && $stable(out_process_count), "stalled result changed")
  `RRPS_ASSERT_NOW(a_empty_ring, out_valid && !out_current_valid, out_current_pid == '0 && out_process_count == '0, "empty ring reports a pid or a count")

endmodule

bind round_robin_process_scheduler_unit rrps_chk u_rrps_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_req.valid),
  .in_ready          (in_req.ready),
  .out_valid         (out_rsp.valid),
  .out_ready         (out_rsp.ready),
  .out_current_pid   (out_rsp.current_pid),
  .out_current_valid (out_rsp.current_valid),
  .out_status        (out_rsp.status),
  .out_process_count (out_rsp.process_count)
);

`default_nettype wire
